FILE: hw/rtl/upc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// upc_pkg
// Character constants and small character classification helpers for the
// URL percent codec.
// ----------------------------------------------------------------------------
package upc_pkg;

    localparam int BYTE_W  = 8;
    localparam int NIB_W   = 4;
    localparam int USER_W  = 3;
    localparam int RUN_MAX = 3;
    localparam int CNT_W   = $clog2(RUN_MAX + 1);

    localparam logic [BYTE_W-1:0] CH_DASH    = 8'h2D;
    localparam logic [BYTE_W-1:0] CH_UNDER   = 8'h5F;
    localparam logic [BYTE_W-1:0] CH_DOT     = 8'h2E;
    localparam logic [BYTE_W-1:0] CH_TILDE   = 8'h7E;
    localparam logic [BYTE_W-1:0] CH_SPACE   = 8'h20;
    localparam logic [BYTE_W-1:0] CH_PLUS    = 8'h2B;
    localparam logic [BYTE_W-1:0] CH_PERCENT = 8'h25;
    localparam logic [BYTE_W-1:0] CH_ZERO    = 8'h30;
    localparam logic [BYTE_W-1:0] CH_NINE    = 8'h39;
    localparam logic [BYTE_W-1:0] CH_UP_A    = 8'h41;
    localparam logic [BYTE_W-1:0] CH_UP_F    = 8'h46;
    localparam logic [BYTE_W-1:0] CH_UP_Z    = 8'h5A;
    localparam logic [BYTE_W-1:0] CH_LO_A    = 8'h61;
    localparam logic [BYTE_W-1:0] CH_LO_F    = 8'h66;
    localparam logic [BYTE_W-1:0] CH_LO_Z    = 8'h7A;

    // Number of nibble values that map to decimal digits.
    localparam logic [NIB_W-1:0] DEC_DIGITS = 4'd10;

    // Bit positions inside the result tuser field.
    localparam int USER_BYTE_VALID = 0;
    localparam int USER_DONE       = 1;
    localparam int USER_ERROR      = 2;

    // Letters, digits and the four marks that stay unchanged when encoding.
    function automatic logic is_unreserved(input logic [BYTE_W-1:0] c);
        logic res;
        res = ((c >= CH_ZERO) && (c <= CH_NINE)) ||
              ((c >= CH_UP_A) && (c <= CH_UP_Z)) ||
              ((c >= CH_LO_A) && (c <= CH_LO_Z)) ||
              (c == CH_DASH) || (c == CH_UNDER) ||
              (c == CH_DOT) || (c == CH_TILDE);
        return res;
    endfunction

    // Uppercase hex character for one nibble.
    function automatic logic [BYTE_W-1:0] hex_char(input logic [NIB_W-1:0] n);
        logic [BYTE_W-1:0] res;
        if (n < DEC_DIGITS)
        begin
            res = CH_ZERO + {4'd0, n};
        end
        else
        begin
            res = CH_UP_A + {4'd0, n - DEC_DIGITS};
        end
        return res;
    endfunction

    // Hex digit value in the low four bits; the top bit is set for a non-hex byte.
    function automatic logic [NIB_W:0] hex_value(input logic [BYTE_W-1:0] c);
        logic [NIB_W:0] res;
        logic [BYTE_W-1:0] diff;
        res = {1'b1, 4'd0};
        if ((c >= CH_ZERO) && (c <= CH_NINE))
        begin
            diff = c - CH_ZERO;
            res  = {1'b0, diff[NIB_W-1:0]};
        end
        else if ((c >= CH_UP_A) && (c <= CH_UP_F))
        begin
            diff = c - CH_UP_A + {4'd0, DEC_DIGITS};
            res  = {1'b0, diff[NIB_W-1:0]};
        end
        else if ((c >= CH_LO_A) && (c <= CH_LO_F))
        begin
            diff = c - CH_LO_A + {4'd0, DEC_DIGITS};
            res  = {1'b0, diff[NIB_W-1:0]};
        end
        return res;
    endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/url_percent_codec_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// url_percent_codec_unit
// Streaming URL percent encoder and decoder for byte strings.
// ----------------------------------------------------------------------------
// Usage:
// Input transactions arrive on the s_axis channel: tdata carries one string
// byte, tlast marks an end-of-string transaction that carries no byte. Result
// transactions leave on the m_axis channel: tdata carries the produced byte,
// tuser flags whether it is a byte, the end-of-string answer, or the error
// report, and tlast marks the last result caused by one input transaction.
// cfg_wr_en / cfg_wr_data select the direction (0 encode, 1 decode) and must
// only be written while the block is idle.
// An accepted transaction is held in the input register; once the result
// register is free, its results are loaded there and presented from it. A
// byte that encodes to an escape gives three results, shifted out of the
// result register one per accepted result transfer; every other transaction
// gives at most one result. Decode bytes that only advance an escape, that
// are in error, or that follow an error, give no result at all.
// The input register keeps accepting while a finished result waits, so a
// stalled receiver stops the block only once both registers are full.
// Reset clears both registers, the direction and the escape state.
// ----------------------------------------------------------------------------
module url_percent_codec_unit
(
    input  wire                          clk,
    input  wire                          rst_n,
    // Configuration: bit 0 is decode_mode.
    input  wire                          cfg_wr_en,
    input  wire                          cfg_wr_data,
    // Input stream.
    input  wire                          s_axis_tvalid,
    output logic                         s_axis_tready,
    input  wire  [upc_pkg::BYTE_W-1:0]   s_axis_tdata,   // [7:0] data_byte
    input  wire                          s_axis_tlast,   // end_marker
    // Result stream.
    output logic                         m_axis_tvalid,
    input  wire                          m_axis_tready,
    output logic [upc_pkg::BYTE_W-1:0]   m_axis_tdata,   // [7:0] out_byte
    output logic [upc_pkg::USER_W-1:0]   m_axis_tuser,   // [0] byte_valid,
                                                         // [1] string_done,
                                                         // [2] decode_error
    output logic                         m_axis_tlast    // run_last
);
    import upc_pkg::*;

    typedef enum logic [1:0]
    {
        PH_PLAIN,
        PH_HIGH,
        PH_LOW
    } phase_t;

    // Configuration and escape state.
    logic               decode_mode_reg;
    phase_t             phase_reg, phase_next;
    logic [NIB_W-1:0]   nibble_reg, nibble_next;
    logic               err_seen_reg, err_seen_next;

    // Input register.
    logic               in_valid_reg;
    logic [BYTE_W-1:0]  in_byte_reg;
    logic               in_end_reg;

    // Result register: a short run of bytes, shifted out one per transaction.
    logic [BYTE_W-1:0]  run_byte_reg [RUN_MAX];
    logic [CNT_W-1:0]   run_cnt_reg;
    logic               run_done_reg;
    logic               run_err_reg;

    // Results computed for the item in the input register.
    logic [BYTE_W-1:0]  res_byte [RUN_MAX];
    logic [CNT_W-1:0]   res_cnt;
    logic               res_done;
    logic               res_err;
    logic [NIB_W:0]     hex_val;
    logic [BYTE_W-1:0]  dec_byte;

    logic s_take;
    logic m_take;
    logic out_free;
    logic proc;

    assign m_axis_tvalid = (run_cnt_reg != '0);
    assign m_take        = m_axis_tvalid && m_axis_tready;
    // The result register can take a new run when it is empty or its last
    // result leaves in this cycle.
    assign out_free      = (run_cnt_reg == '0) ||
                           (m_take && (run_cnt_reg == CNT_W'(1)));
    assign proc          = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || proc;
    assign s_take        = s_axis_tvalid && s_axis_tready;

    assign m_axis_tdata                  = run_byte_reg[0];
    assign m_axis_tuser[USER_BYTE_VALID] = !run_done_reg;
    assign m_axis_tuser[USER_DONE]       = run_done_reg;
    assign m_axis_tuser[USER_ERROR]      = run_err_reg;
    assign m_axis_tlast                  = (run_cnt_reg == CNT_W'(1));

    assign hex_val  = hex_value(in_byte_reg);
    assign dec_byte = {nibble_reg, hex_val[NIB_W-1:0]};

    always_comb
    begin
        res_byte[0]   = '0;
        res_byte[1]   = '0;
        res_byte[2]   = '0;
        res_cnt       = '0;
        res_done      = 1'b0;
        res_err       = 1'b0;
        phase_next    = phase_reg;
        nibble_next   = nibble_reg;
        err_seen_next = err_seen_reg;

        if (in_end_reg)
        begin
            // End of string: report a sticky error or an unfinished escape.
            res_cnt       = CNT_W'(1);
            res_done      = 1'b1;
            res_err       = err_seen_reg || (phase_reg != PH_PLAIN);
            phase_next    = PH_PLAIN;
            nibble_next   = '0;
            err_seen_next = 1'b0;
        end
        else if (!decode_mode_reg)
        begin
            if (is_unreserved(in_byte_reg))
            begin
                res_cnt     = CNT_W'(1);
                res_byte[0] = in_byte_reg;
            end
            else if (in_byte_reg == CH_SPACE)
            begin
                res_cnt     = CNT_W'(1);
                res_byte[0] = CH_PLUS;
            end
            else
            begin
                res_cnt     = CNT_W'(RUN_MAX);
                res_byte[0] = CH_PERCENT;
                res_byte[1] = hex_char(in_byte_reg[BYTE_W-1:NIB_W]);
                res_byte[2] = hex_char(in_byte_reg[NIB_W-1:0]);
            end
        end
        else if (!err_seen_reg)
        begin
            unique case (phase_reg)
                PH_PLAIN:
                begin
                    if (in_byte_reg == CH_PERCENT)
                    begin
                        phase_next = PH_HIGH;
                    end
                    else
                    begin
                        res_cnt     = CNT_W'(1);
                        res_byte[0] = (in_byte_reg == CH_PLUS) ? CH_SPACE : in_byte_reg;
                    end
                end
                PH_HIGH:
                begin
                    if (hex_val[NIB_W])
                    begin
                        err_seen_next = 1'b1;
                        phase_next    = PH_PLAIN;
                    end
                    else
                    begin
                        nibble_next = hex_val[NIB_W-1:0];
                        phase_next  = PH_LOW;
                    end
                end
                default:
                begin
                    phase_next = PH_PLAIN;
                    if (hex_val[NIB_W] || (dec_byte == '0))
                    begin
                        // A non-hex digit or an encoded zero byte.
                        err_seen_next = 1'b1;
                    end
                    else
                    begin
                        res_cnt     = CNT_W'(1);
                        res_byte[0] = dec_byte;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decode_mode_reg <= 1'b0;
            phase_reg       <= PH_PLAIN;
            nibble_reg      <= '0;
            err_seen_reg    <= 1'b0;
            in_valid_reg    <= 1'b0;
            run_cnt_reg     <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                decode_mode_reg <= cfg_wr_data;
            end

            if (s_take)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (proc)
            begin
                in_valid_reg <= 1'b0;
            end

            if (proc)
            begin
                phase_reg    <= phase_next;
                nibble_reg   <= nibble_next;
                err_seen_reg <= err_seen_next;
                run_cnt_reg  <= res_cnt;
            end
            else if (m_take)
            begin
                run_cnt_reg <= run_cnt_reg - CNT_W'(1);
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (s_take)
        begin
            in_byte_reg <= s_axis_tdata;
            in_end_reg  <= s_axis_tlast;
        end

        if (proc)
        begin
            run_byte_reg[0] <= res_byte[0];
            run_byte_reg[1] <= res_byte[1];
            run_byte_reg[2] <= res_byte[2];
            run_done_reg    <= res_done;
            run_err_reg     <= res_err;
        end
        else if (m_take)
        begin
            run_byte_reg[0] <= run_byte_reg[1];
            run_byte_reg[1] <= run_byte_reg[2];
            run_byte_reg[2] <= '0;
        end
    end

    // The end-of-string answer is always a run of one result.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[USER_DONE]) |-> m_axis_tlast)
        else $error("end-of-string result is not the last of its run");

    // The end-of-string answer carries no byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[USER_DONE]) |-> (m_axis_tdata == '0))
        else $error("end-of-string result carries a byte");

    // An error is only reported on the end-of-string answer.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[USER_ERROR]) |-> m_axis_tuser[USER_DONE])
        else $error("decode error flagged on a byte result");

    // Once a result that is not the last of its run is taken, the run goes on.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=> m_axis_tvalid)
        else $error("result run broken off before its last result");

endmodule
`default_nettype wire
